@@ hdl/smvm_pkg.sv @@
`timescale 1ns / 1ps

package smvm_pkg;

   localparam int DEFAULT_VECTOR_DEPTH = 1024;
   localparam int INDEX_W              = 10;
   localparam int X_W                  = 32;
   localparam int WEIGHT_W             = 16;
   localparam int PROD_W               = X_W + WEIGHT_W;
   localparam int Y_W                  = 64;

   // Request function codes
   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_NONZERO = 2'd1;
   localparam logic [1:0] FUNC_CLOSE   = 2'd2;

   // Configuration register indexes
   localparam logic CSR_USE_WEIGHTS  = 1'b0;
   localparam logic CSR_BOOLEAN_MODE = 1'b1;

   // Unit weight in Q8.8
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_ONE = 16'sd256;

   // Result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [1:0]                 func;
      logic [INDEX_W-1:0]         index;
      logic signed [X_W-1:0]      x_value;
      logic signed [WEIGHT_W-1:0] weight;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  row_number;
      logic signed [Y_W-1:0] y_value;
   } rsp_type;

   // Looked-up operand pair handed from the vector store to the MAC
   typedef struct packed {
      logic                       valid;
      logic [1:0]                 func;
      logic                       in_range;
      logic signed [X_W-1:0]      x;
      logic signed [WEIGHT_W-1:0] weight;
   } lookup_type;

endpackage

@@ hdl/smvm_vector_store.sv @@
`timescale 1ns / 1ps

module smvm_vector_store #(
   parameter int VECTOR_DEPTH = smvm_pkg::DEFAULT_VECTOR_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  smvm_pkg::req_type    req,
   output smvm_pkg::lookup_type lookup
);
   import smvm_pkg::*;

   localparam int ADDR_W = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

   logic signed [X_W-1:0] mem [VECTOR_DEPTH];

   logic [ADDR_W-1:0]          addr;
   logic                       in_range;
   logic signed [X_W-1:0]      rd_ff;
   logic                       valid_ff;
   logic [1:0]                 func_ff;
   logic                       in_range_ff;
   logic signed [WEIGHT_W-1:0] weight_ff;

   assign addr     = ADDR_W'(req.index);
   assign in_range = (32'(req.index) < 32'(VECTOR_DEPTH));

   // Write happens at the accepting edge, so a following request sees it.
   always_ff @(posedge clock) begin
      if (accept && req.func == FUNC_LOAD && in_range) begin
         mem[addr] <= req.x_value;
      end
      if (accept) begin
         rd_ff       <= mem[addr];
         func_ff     <= req.func;
         in_range_ff <= in_range;
         weight_ff   <= req.weight;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   assign lookup.valid    = valid_ff;
   assign lookup.func     = func_ff;
   assign lookup.in_range = in_range_ff;
   assign lookup.x        = rd_ff;
   assign lookup.weight   = weight_ff;

endmodule

@@ hdl/smvm_mac.sv @@
`timescale 1ns / 1ps

module smvm_mac #(
   parameter int VECTOR_DEPTH = smvm_pkg::DEFAULT_VECTOR_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  smvm_pkg::lookup_type lookup,
   input  logic                 use_weights,
   input  logic                 boolean_mode,
   output logic                 push,
   output smvm_pkg::rsp_type    push_data,
   output logic [1:0]           pending
);
   import smvm_pkg::*;

   logic signed [X_W-1:0]      x_eff;
   logic signed [WEIGHT_W-1:0] w_eff;
   logic signed [PROD_W-1:0]   prod_in;
   logic                       hit_in;

   logic                       valid2_ff;
   logic [1:0]                 func2_ff;
   logic signed [PROD_W-1:0]   prod2_ff;
   logic                       hit2_ff;

   logic signed [Y_W-1:0]      acc_ff, acc_in;
   logic                       hit_ff, hit_in2;
   logic [INDEX_W-1:0]         row_ff, row_in;

   logic [Y_W:0]               sum;
   logic [INDEX_W:0]           row_next;
   logic                       is_nonzero2;
   logic                       is_close2;

   assign x_eff   = lookup.in_range ? lookup.x : '0;
   assign w_eff   = use_weights ? lookup.weight : WEIGHT_ONE;
   assign prod_in = PROD_W'(x_eff) * PROD_W'(w_eff);
   assign hit_in  = lookup.in_range && (lookup.x != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= lookup.valid;
      end
      func2_ff <= lookup.func;
      prod2_ff <= prod_in;
      hit2_ff  <= hit_in;
   end

   assign is_nonzero2 = valid2_ff && func2_ff == FUNC_NONZERO;
   assign is_close2   = valid2_ff && func2_ff == FUNC_CLOSE;

   // Saturating accumulate: overflow when the two top bits of the 65-bit sum differ
   assign sum      = {acc_ff[Y_W-1], acc_ff} + (Y_W+1)'(prod2_ff);
   assign row_next = {1'b0, row_ff} + 1'b1;

   always_comb begin
      acc_in  = acc_ff;
      hit_in2 = hit_ff;
      row_in  = row_ff;
      if (is_nonzero2) begin
         hit_in2 = hit_ff | hit2_ff;
         if (sum[Y_W] != sum[Y_W-1]) begin
            acc_in = sum[Y_W] ? {1'b1, {(Y_W-1){1'b0}}} : {1'b0, {(Y_W-1){1'b1}}};
         end else begin
            acc_in = sum[Y_W-1:0];
         end
      end else if (is_close2) begin
         acc_in  = '0;
         hit_in2 = 1'b0;
         if (row_next[INDEX_W] || 32'(row_next) >= 32'(VECTOR_DEPTH)) begin
            row_in = '0;
         end else begin
            row_in = row_next[INDEX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         hit_ff <= 1'b0;
         row_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         hit_ff <= hit_in2;
         row_ff <= row_in;
      end
   end

   assign push                 = is_close2;
   assign push_data.row_number = row_ff;
   assign push_data.y_value    = boolean_mode ? Y_W'(hit_ff) : acc_ff;

   // Closes still travelling toward the result queue
   assign pending = 2'(lookup.valid && lookup.func == FUNC_CLOSE) + 2'(is_close2);

endmodule

@@ hdl/smvm_result_queue.sv @@
`timescale 1ns / 1ps

module smvm_result_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  smvm_pkg::rsp_type           push_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output smvm_pkg::rsp_type           rsp_data,
   output logic [smvm_pkg::QCNT_W-1:0] count
);
   import smvm_pkg::*;

   rsp_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

@@ hdl/sparse_matrix_vector_multiply.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   smvm_pkg::req_type (func, index, x_value, weight)
// rsp_      out        rsp_valid/rsp_stall   smvm_pkg::rsp_type (row_number, y_value)
// csr_      in         csr_wr_en             csr_index, csr_wr_data
//
// One request per cycle while req_stall is low; a close's row result reaches rsp_ through
// the vector store read register, the multiply register and the queue write.
// The vector store memory is written and read at the accepting edge; its contents
// are not cleared by reset, only control state, the accumulator and row counter are.
// A four-entry result queue takes results; req_stall rises only when the queue plus
// closes still in the pipeline could fill it, so rsp_stall has no combinational path to req_stall.

module sparse_matrix_vector_multiply #(
   parameter int VECTOR_DEPTH = smvm_pkg::DEFAULT_VECTOR_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  smvm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output smvm_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic              csr_wr_data
);
   import smvm_pkg::*;

   logic              use_weights_ff;
   logic              boolean_mode_ff;
   logic              accept;
   lookup_type        lookup;
   logic              push;
   rsp_type           push_data;
   logic [1:0]        pending;
   logic [QCNT_W-1:0] count;
   logic [QCNT_W:0]   committed;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_weights_ff  <= 1'b1;
         boolean_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_USE_WEIGHTS:  use_weights_ff  <= csr_wr_data;
            CSR_BOOLEAN_MODE: boolean_mode_ff <= csr_wr_data;
            default:          use_weights_ff  <= use_weights_ff;
         endcase
      end
   end

   assign committed = (QCNT_W+1)'(count) + (QCNT_W+1)'(pending);
   assign req_stall = (32'(committed) >= 32'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   smvm_vector_store #(
      .VECTOR_DEPTH(VECTOR_DEPTH)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .lookup (lookup)
   );

   smvm_mac #(
      .VECTOR_DEPTH(VECTOR_DEPTH)
   ) u_mac (
      .clock        (clock),
      .reset        (reset),
      .lookup       (lookup),
      .use_weights  (use_weights_ff),
      .boolean_mode (boolean_mode_ff),
      .push         (push),
      .push_data    (push_data),
      .pending      (pending)
   );

   smvm_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .count     (count)
   );

endmodule
